FILE: rtl/rtdt_pkg.sv
// rtdt_pkg: shared widths, register indexes and fixed-point constants for the
// rtd ratio to temperature pipeline
// no dependencies
package rtdt_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CODE_W = 15;
  localparam int OHM_W  = 16;
  localparam int PROD_W = 31;
  localparam int RES_W  = 23;
  localparam int TEMP_W = 18;
  localparam int TQ_W   = 19;
  localparam int R_W    = 23;
  localparam int ACC_W  = 44;
  localparam int TP_W   = 28;
  localparam int SQ_W   = 64;
  localparam int SQ_STEPS = 32;
  localparam int POLY_STEPS = 5;
  localparam int POLY_LO_W = 22;

  // register indexes on the write port
  localparam logic [0:0] REG_NOMINAL   = 1'b0;
  localparam logic [0:0] REG_REFERENCE = 1'b1;

  localparam logic [OHM_W-1:0] NOMINAL_RST   = 16'd1000;
  localparam logic [OHM_W-1:0] REFERENCE_RST = 16'd4000;

  // callendar-van dusen terms, scaled to integers
  localparam longint CVD_A_E7    = 39083;
  localparam longint CVD_A2      = 1527480889;
  localparam longint CVD_4B_E14  = 231000000;
  localparam longint QUAD_SCALE  = 2000000000;

  localparam int T_MAX = 100000;
  localparam int T_MIN = -25000;

  // horner coefficients, centidegrees, highest order first
  localparam logic signed [ACC_W-1:0] POLY_C5 = 44'sd1098373906;
  localparam logic signed [ACC_W-1:0] POLY_ADD [POLY_STEPS] = '{
    -44'sd203079917277,
    -44'sd135839823761,
     44'sd284322711827,
     44'sd238671332639,
    -44'sd1586102272
  };
  localparam int POLY_SH [POLY_STEPS] = '{16, 24, 24, 26, 30};
  localparam logic signed [ACC_W-1:0] POLY_HALF = 44'sd32768;
  localparam int POLY_OUT_SH = 16;

endpackage

FILE: rtl/rtdt_pipe_div.sv
// rtdt_pipe_div: restoring divider, one quotient bit per register stage,
// with a side word carried alongside; needs num < den * 2^Q_W
// no dependencies
module rtdt_pipe_div #(
  parameter int NUM_W  = 47,
  parameter int DEN_W  = 31,
  parameter int Q_W    = 19,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int W = DEN_W + Q_W;

  logic [W-1:0]      rem  [Q_W-1];
  logic [DEN_W-1:0]  dv   [Q_W-1];
  logic [Q_W-1:0]    qv   [Q_W];
  logic [SIDE_W-1:0] sd   [Q_W];
  logic              vld  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [W-1:0]      rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    q_in;
    logic [SIDE_W-1:0] side_k;
    logic              v_in;
    logic [W-1:0]      trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign side_k = side_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dv[k-1];
      assign q_in   = qv[k-1];
      assign side_k = sd[k-1];
      assign v_in   = vld[k-1];
    end

    assign trial = W'(den_in) << (Q_W - 1 - k);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k] <= {q_in[Q_W-2:0], take};
        sd[k] <= side_k;
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= take ? rem_in - trial : rem_in;
          dv[k]  <= den_in;
        end
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = qv[Q_W-1];
  assign side_out  = sd[Q_W-1];

endmodule

FILE: rtl/rtdt_isqrt.sv
// rtdt_isqrt: 64-bit integer square root, one result bit per register stage,
// side word carried alongside
// depends on rtdt_pkg
module rtdt_isqrt
  import rtdt_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);

  logic [SQ_W-1:0]   vr  [SQ_STEPS-1];
  logic [SQ_W-1:0]   res [SQ_STEPS];
  logic [SIDE_W-1:0] sd  [SQ_STEPS];
  logic              vld [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    logic [SQ_W-1:0]   v_in;
    logic [SQ_W-1:0]   res_in;
    logic [SIDE_W-1:0] side_k;
    logic              ok_in;
    logic [SQ_W-1:0]   bitk;
    logic [SQ_W-1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in   = radicand;
      assign res_in = '0;
      assign side_k = side_in;
      assign ok_in  = in_valid;
    end else begin : g_next
      assign v_in   = vr[k-1];
      assign res_in = res[k-1];
      assign side_k = sd[k-1];
      assign ok_in  = vld[k-1];
    end

    assign bitk  = SQ_W'(1) << (62 - 2 * k);
    assign trial = res_in + bitk;
    assign take  = v_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= ok_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res[k] <= take ? (res_in >> 1) + bitk : res_in >> 1;
        sd[k]  <= side_k;
      end
    end

    if (k < SQ_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          vr[k] <= take ? v_in - trial : v_in;
        end
      end
    end
  end

  assign out_valid = vld[SQ_STEPS-1];
  assign root      = res[SQ_STEPS-1][31:0];
  assign side_out  = sd[SQ_STEPS-1];

endmodule

FILE: rtl/rtdt_poly.sv
// rtdt_poly: fifth-order horner evaluation for the sub-zero range, two register
// stages per step (split partial products, then sum, shift, add)
// depends on rtdt_pkg
module rtdt_poly
  import rtdt_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [R_W-1:0]         r,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic signed [TP_W-1:0] tp,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int PL_W = POLY_LO_W + R_W;
  localparam int PH_W = ACC_W - POLY_LO_W + R_W + 1;
  localparam int FULL_W = ACC_W + R_W + 1;

  logic [PL_W-1:0]          pl  [POLY_STEPS];
  logic signed [PH_W-1:0]   ph  [POLY_STEPS];
  logic [R_W-1:0]           ra  [POLY_STEPS];
  logic [SIDE_W-1:0]        sda [POLY_STEPS];
  logic                     va  [POLY_STEPS];
  logic signed [ACC_W-1:0]  acc [POLY_STEPS];
  logic [R_W-1:0]           rb  [POLY_STEPS-1];
  logic [SIDE_W-1:0]        sdb [POLY_STEPS];
  logic                     vb  [POLY_STEPS];

  for (genvar k = 0; k < POLY_STEPS; k++) begin : g_step
    logic signed [ACC_W-1:0]  acc_in;
    logic [R_W-1:0]           r_in;
    logic [SIDE_W-1:0]        side_k;
    logic                     v_in;
    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] shifted;

    if (k == 0) begin : g_first
      assign acc_in = POLY_C5;
      assign r_in   = r;
      assign side_k = side_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign acc_in = acc[k-1];
      assign r_in   = rb[k-1];
      assign side_k = sdb[k-1];
      assign v_in   = vb[k-1];
    end

    // partial products: unsigned low slice, signed high slice
    always_ff @(posedge clk) begin
      if (rst) begin
        va[k] <= 1'b0;
      end else if (en) begin
        va[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl[k]  <= PL_W'(acc_in[POLY_LO_W-1:0]) * PL_W'(r_in);
        ph[k]  <= $signed(acc_in[ACC_W-1:POLY_LO_W]) * $signed({1'b0, r_in});
        ra[k]  <= r_in;
        sda[k] <= side_k;
      end
    end

    assign full    = (FULL_W'(ph[k]) <<< POLY_LO_W) + $signed(FULL_W'(pl[k]));
    assign shifted = full >>> POLY_SH[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        vb[k] <= 1'b0;
      end else if (en) begin
        vb[k] <= va[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= ACC_W'(shifted) + POLY_ADD[k];
        sdb[k] <= sda[k];
      end
    end

    if (k < POLY_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rb[k] <= ra[k];
        end
      end
    end
  end

  logic signed [ACC_W-1:0] rounded;
  assign rounded = (acc[POLY_STEPS-1] + POLY_HALF) >>> POLY_OUT_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb[POLY_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp       <= TP_W'(rounded);
      side_out <= sdb[POLY_STEPS-1];
    end
  end

endmodule

FILE: rtl/rtd_ratio_to_temperature.sv
// rtd_ratio_to_temperature: top level, configuration registers, glue stages,
// branch select and output register
// depends on rtdt_pkg, rtdt_pipe_div, rtdt_isqrt, rtdt_poly
//
// Converts a 15-bit ratio code to RTD resistance (centiohm) and temperature in
// hundredths of a degree C, one request per clock unless the output stalls. The
// datapath is a single pipeline of FRAC_BITS+69 register stages (85 at the
// default): ratio product, a bit-per-stage ratio divider (FRAC_BITS+3),
// constant multiplies, the sub-zero polynomial (11), a bit-per-stage square
// root (32), the root denominator, a bit-per-stage root divider (19) and the
// output register. A stall on the output freezes the whole pipeline, so no
// request is accepted while it lasts. A nominal resistance of zero is taken as
// one ohm. Write configuration only while the pipeline is empty.
module rtd_ratio_to_temperature
  import rtdt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [OHM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CODE_W-1:0]        ratio_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [RES_W-1:0]         resistance_centiohm,
  output logic signed [TEMP_W-1:0] temp_centideg,
  output logic                     used_polynomial,
  output logic                     saturated
);

  localparam int XQ_W   = FRAC_BITS + 3;
  localparam int NUM1_W = PROD_W + FRAC_BITS;
  localparam int DEN1_W = PROD_W;
  localparam int DM_W   = FRAC_BITS + 31;
  localparam int DN_W   = FRAC_BITS + 32;
  localparam int NM_W   = FRAC_BITS + 34;
  localparam int NUM2_W = NM_W + 16;
  localparam int DEN2_W = FRAC_BITS + 33;
  localparam int R_LSH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int R_RSH  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam logic [XQ_W-1:0] ONE = XQ_W'(1) << FRAC_BITS;

  localparam int SIDE1_W = RES_W + 1;
  localparam int SIDE2_W = RES_W + 3 + NM_W + SQ_W;
  localparam int SIDE3_W = RES_W + 3 + NM_W + TP_W;
  localparam int SIDE4_W = RES_W + 3 + TP_W;

  localparam logic signed [TP_W-1:0] T_MAX_W = TP_W'(T_MAX);
  localparam logic signed [TP_W-1:0] T_MIN_W = TP_W'(T_MIN);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // configuration registers
  logic [OHM_W-1:0] nominal_ohms;
  logic [OHM_W-1:0] reference_ohms;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_ohms   <= NOMINAL_RST;
      reference_ohms <= REFERENCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOMINAL:   nominal_ohms   <= cfg_data;
        REG_REFERENCE: reference_ohms <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: code times reference
  logic              va;
  logic [PROD_W-1:0] prod_a;
  logic [OHM_W-1:0]  r0_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= PROD_W'(ratio_code) * PROD_W'(reference_ohms);
      r0_a   <= (nominal_ohms == '0) ? OHM_W'(1) : nominal_ohms;
    end
  end

  logic [38:0]        res_full;
  logic               ovf_a;
  logic [SIDE1_W-1:0] side1_in;
  assign res_full = 39'(prod_a) * 39'd100;
  // ratio of eight or more goes straight to the high clamp
  assign ovf_a    = 34'(prod_a) >= (34'(r0_a) << 18);
  assign side1_in = {res_full[37:15], ovf_a};

  logic               v1;
  logic [XQ_W-1:0]    xq;
  logic [SIDE1_W-1:0] side1_out;

  rtdt_pipe_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DEN1_W),
    .Q_W    (XQ_W),
    .SIDE_W (SIDE1_W)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va),
    .num       (NUM1_W'(prod_a) << FRAC_BITS),
    .den       (DEN1_W'(r0_a) << 15),
    .side_in   (side1_in),
    .out_valid (v1),
    .quo       (xq),
    .side_out  (side1_out)
  );

  // stage c: constant multiplies for both branches
  logic             below_one;
  logic [XQ_W-1:0]  dx;
  logic [39:0]      rw;
  assign below_one = xq < ONE;
  assign dx        = below_one ? '0 : xq - ONE;
  assign rw        = 40'(xq) * 40'd100;

  logic              vc;
  logic [DM_W-1:0]   dm_c;
  logic [NM_W-1:0]   nm_c;
  logic [R_W-1:0]    r_c;
  logic              poly_c;
  logic              ovf_c;
  logic [RES_W-1:0]  res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_c   <= DM_W'(dx) * DM_W'(CVD_4B_E14);
      nm_c   <= NM_W'(dx) * NM_W'(QUAD_SCALE);
      r_c    <= R_W'((rw << R_LSH) >> R_RSH);
      poly_c <= below_one;
      ovf_c  <= side1_out[0];
      res_c  <= side1_out[SIDE1_W-1:1];
    end
  end

  // discriminant, widened to scale 2^32
  logic signed [DN_W-1:0] dn;
  logic                   neg_c;
  logic [SQ_W-1:0]        dw;
  assign dn    = (DN_W'(CVD_A2) << FRAC_BITS) - DN_W'(dm_c);
  assign neg_c = dn[DN_W-1];
  assign dw    = neg_c ? '0 : SQ_W'(dn[DN_W-2:0]) << (32 - FRAC_BITS);

  logic               v2;
  logic signed [TP_W-1:0] tp;
  logic [SIDE2_W-1:0] side2_out;

  rtdt_poly #(
    .SIDE_W (SIDE2_W)
  ) u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc),
    .r         (r_c),
    .side_in   ({res_c, ovf_c, poly_c, neg_c, nm_c, dw}),
    .out_valid (v2),
    .tp        (tp),
    .side_out  (side2_out)
  );

  logic               v3;
  logic [31:0]        root;
  logic [SIDE3_W-1:0] side3_out;

  rtdt_isqrt #(
    .SIDE_W (SIDE3_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .radicand  (side2_out[SQ_W-1:0]),
    .side_in   ({side2_out[SIDE2_W-1:SQ_W], tp}),
    .out_valid (v3),
    .root      (root),
    .side_out  (side3_out)
  );

  // stage e: denominator of the rationalised root
  logic               ve;
  logic [DEN2_W-1:0]  den_e;
  logic [NUM2_W-1:0]  num_e;
  logic [SIDE4_W-1:0] side4_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_e   <= DEN2_W'((33'(CVD_A_E7) << 16) + 33'(root)) << FRAC_BITS;
      num_e   <= NUM2_W'(side3_out[TP_W+NM_W-1:TP_W]) << 16;
      side4_e <= {side3_out[SIDE3_W-1:TP_W+NM_W], side3_out[TP_W-1:0]};
    end
  end

  logic               v4;
  logic [TQ_W-1:0]    tq;
  logic [SIDE4_W-1:0] side4_out;

  rtdt_pipe_div #(
    .NUM_W  (NUM2_W),
    .DEN_W  (DEN2_W),
    .Q_W    (TQ_W),
    .SIDE_W (SIDE4_W)
  ) u_root_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ve),
    .num       (num_e),
    .den       (den_e),
    .side_in   (side4_e),
    .out_valid (v4),
    .quo       (tq),
    .side_out  (side4_out)
  );

  // branch select and clamp
  logic [RES_W-1:0]       res_f;
  logic                   ovf_f;
  logic                   poly_f;
  logic                   neg_f;
  logic signed [TP_W-1:0] tp_f;
  logic                   high_f;
  logic signed [TP_W-1:0] t_sel;
  logic                   over;
  logic                   under;

  assign {res_f, ovf_f, poly_f, neg_f, tp_f} = side4_out;
  assign high_f = ovf_f || (!poly_f && neg_f);

  always_comb begin
    if (high_f) begin
      t_sel = T_MAX_W + TP_W'(1);
    end else if (poly_f) begin
      t_sel = tp_f;
    end else begin
      t_sel = $signed(TP_W'(tq));
    end
  end

  assign over  = t_sel > T_MAX_W;
  assign under = t_sel < T_MIN_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      resistance_centiohm <= res_f;
      temp_centideg       <= over ? TEMP_W'(T_MAX_W) :
                             under ? TEMP_W'(T_MIN_W) : TEMP_W'(t_sel);
      used_polynomial     <= poly_f || high_f;
      saturated           <= over || under;
    end
  end

`ifndef NO_ASSERTIONS
  // the quadratic root is never negative
  a_quad_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !used_polynomial |-> !temp_centideg[TEMP_W-1])
    else $error("quadratic branch gave a negative temperature");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      temp_centideg == TEMP_W'(T_MAX_W) || temp_centideg == TEMP_W'(T_MIN_W))
    else $error("clamped temperature not at a limit");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temp_centideg <= TEMP_W'(T_MAX_W) && temp_centideg >= TEMP_W'(T_MIN_W))
    else $error("temperature outside output range");

  // input is only held back by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");
`endif

endmodule

FILE: dv/rtdt_checker.sv
// rtdt_checker: watches the request and result channels of the rtd converter,
// predicts each result from a model of its own and counts mismatches
// depends on rtdt_pkg
module rtdt_checker
  import rtdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [OHM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [CODE_W-1:0]        ratio_code,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [RES_W-1:0]         resistance_centiohm,
  input  logic signed [TEMP_W-1:0] temp_centideg,
  input  logic                     used_polynomial,
  input  logic                     saturated,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [RES_W-1:0]         res;
    logic signed [TEMP_W-1:0] temp;
    logic                     poly;
    logic                     sat;
  } reading_t;

  reading_t expected_readings[$];
  logic [OHM_W-1:0] nominal_q, reference_q;

  assign pending = expected_readings.size();

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint cold_poly(longint unsigned xq);
    longint r, acc;
    r = longint'((100 * xq) >> (FB - 16));
    acc = POLY_C5;
    for (int i = 0; i < POLY_STEPS; i++)
      acc = POLY_ADD[i] + fshift(acc * r, POLY_SH[i]);
    return fshift(acc + 32768, 16);
  endfunction

  function automatic reading_t convert(logic [CODE_W-1:0] code);
    reading_t rd;
    longint unsigned r0, prod, one, xq, dw, s, den, n, q, rem, v;
    longint t, dn;
    rd.poly = 0;
    rd.sat = 0;
    r0 = (nominal_q == 0) ? 1 : nominal_q;
    prod = longint'(code) * reference_q;
    one = 64'd1 << FB;
    xq = (prod << FB) / (r0 << 15);
    if (xq < one) begin
      rd.poly = 1;
      t = cold_poly(xq);
    end else if (xq >= 8 * one) begin
      rd.poly = 1;
      t = T_MAX + 1;
    end else begin
      dn = CVD_A2 * longint'(one) + CVD_4B_E14 * (longint'(one) - longint'(xq));
      if (dn < 0) begin
        rd.poly = 1;
        t = T_MAX + 1;
      end else begin
        dw = longint'(dn) << (32 - FB);
        s = root64(dw);
        den = (CVD_A_E7 << 16) + s;
        n = QUAD_SCALE * (xq - one);
        q = n / den;
        rem = n % den;
        v = (q << 16) + ((rem << 16) / den);
        t = longint'(v >> FB);
      end
    end
    if (t > T_MAX) begin
      t = T_MAX;
      rd.sat = 1;
    end else if (t < T_MIN) begin
      t = T_MIN;
      rd.sat = 1;
    end
    rd.res = RES_W'((prod * 100) >> 15);
    rd.temp = TEMP_W'(t);
    return rd;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      nominal_q <= NOMINAL_RST;
      reference_q <= REFERENCE_RST;
      fail_count <= 0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NOMINAL) nominal_q <= cfg_data;
        else nominal_q <= nominal_q;
        if (cfg_index == REG_REFERENCE) reference_q <= cfg_data;
      end
      if (in_valid && !in_stall) expected_readings.push_back(convert(ratio_code));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result with nothing expected: res %0d temp %0d", $time,
                   resistance_centiohm, temp_centideg);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_readings.pop_front();
          if (want.res !== resistance_centiohm || want.temp !== temp_centideg ||
              want.poly !== used_polynomial || want.sat !== saturated) begin
            $display("%0t: expected res %0d temp %0d poly %0b sat %0b, got %0d %0d %0b %0b",
                     $time, want.res, want.temp, want.poly, want.sat,
                     resistance_centiohm, temp_centideg, used_polynomial, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_rtd_ratio_to_temperature.sv
// tb_rtd_ratio_to_temperature: stimulus, clock, reset and verdict for the rtd
// converter; depends on rtdt_pkg, rtdt_checker and the block itself
module tb_rtd_ratio_to_temperature;
  import rtdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = FRAC_BITS_DEF + 69;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0, rst = 1, cfg_we = 0, in_valid = 0, out_stall = 0;
  logic [0:0] cfg_index = REG_NOMINAL;
  logic [OHM_W-1:0] cfg_data = '0;
  logic [CODE_W-1:0] ratio_code = '0;
  logic in_stall, out_valid, used_polynomial, saturated;
  logic [RES_W-1:0] resistance_centiohm;
  logic signed [TEMP_W-1:0] temp_centideg;
  int fail_count, pending, idle_cycles;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rtd_ratio_to_temperature dut (.*);
  rtdt_checker chk (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // result side stalls at random, with calm stretches
  always @(negedge clk) begin
    if (!rst && ($urandom_range(9) < 3)) out_stall <= ($urandom_range(3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays up between back-to-back requests and drops only for a gap
  task automatic send_request(logic [CODE_W-1:0] code, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    ratio_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [OHM_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic random_burst(int count);
    int p;
    logic [CODE_W-1:0] c;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(9);
      if (p == 0) c = CODE_W'($urandom_range(32767, 32700));
      else if (p == 1) c = CODE_W'($urandom_range(60));
      else c = CODE_W'($urandom_range(32767));
      send_request(c, ($urandom_range(4) != 0));
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    logic [OHM_W-1:0] nom_set [6] = '{1000, 100, 65535, 0, 1, 4000};
    logic [OHM_W-1:0] ref_set [6] = '{4000, 400, 1, 65535, 0, 3300};
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // extremes, zero crossing at ratio 1/4, bit walk
    send_request(15'd0, 1'b0);
    send_request(15'h7FFF, 1'b0);
    send_request(15'd8192, 1'b0);
    send_request(15'd8191, 1'b0);
    send_request(15'd8193, 1'b0);
    send_request(15'd16384, 1'b0);
    send_request(15'd4000, 1'b0);
    for (int b = 0; b < CODE_W; b++) send_request(CODE_W'(1) << b, 1'b0);
    send_request(15'h5555, 1'b0);
    send_request(15'h2AAA, 1'b0);
    drain();
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_NOMINAL, nom_set[k]);
      write_reg(REG_REFERENCE, ref_set[k]);
      random_burst(k == 5 ? 196 : 100);
      drain();
    end
    // random register values over the full bit range
    write_reg(REG_NOMINAL, 16'($urandom));
    write_reg(REG_REFERENCE, 16'($urandom));
    random_burst(30);
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
